FILE: hw/rtl/lrh_pkg.sv
package lrh_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam int REG_LOOP_LENGTH = 0;
    localparam int REG_SPEED       = 1;
    localparam int REG_LEVEL_GAIN  = 2;
    localparam int REG_RAMP_STEP   = 3;

    localparam logic [16:0] UNITY_MUTE = 17'd32768;
    localparam logic [15:0] DECAY_Q16  = 16'd65470;
    localparam int GAIN_SHIFT = 12;
    localparam int MUTE_SHIFT = 15;

    // one classified item handed from the front to the back
    typedef struct packed {
        cmd_t        cmd;
        logic        muted;
        logic [31:0] wrap_pos;
        logic [31:0] sync_position;
        logic [23:0] write_address;
        logic [31:0] write_sample;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDX,
        ST_RD0,
        ST_RD1,
        ST_MUL0,
        ST_MUL1,
        ST_GAIN,
        ST_MUTE,
        ST_METER,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/lrh_queue.sv
module lrh_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lrh_pkg::item_t   push_item,
    output logic             full,
    input  logic             pop,
    output lrh_pkg::item_t   pop_item,
    output logic             empty
);
    import lrh_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
            count_next  = count_next + 2'd1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
            count_next  = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_ptr_reg] <= push_item;
    end
endmodule

FILE: hw/rtl/lrh_front.sv
module lrh_front #(
    parameter int ADDR_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             cmd,
    input  logic                   muted,
    input  logic [31:0]            wrap_pos,
    input  logic [31:0]            sync_position,
    input  logic [ADDR_BITS-1:0]   write_address,
    input  logic [SAMPLE_BITS-1:0] write_sample,
    output logic                   q_push,
    output lrh_pkg::item_t         q_item,
    input  logic                   q_full
);
    import lrh_pkg::*;

    // drop unknown commands here so the back never sees them
    assign full   = q_full;
    assign q_push = push && (cmd != CMD_NONE);

    always_comb
    begin
        q_item               = '0;
        q_item.cmd           = cmd_t'(cmd);
        q_item.muted         = muted;
        q_item.wrap_pos      = wrap_pos;
        q_item.sync_position = sync_position;
        q_item.write_address = 24'(write_address);
        q_item.write_sample  = 32'(signed'(write_sample));
    end
endmodule

FILE: hw/rtl/lrh_divider.sv
module lrh_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [33:0] trial;

    assign remainder = rem_reg[31:0];
    assign done      = busy_reg && (cnt_reg == 6'd0);

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[32]} - {2'b0, divisor};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd33;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
                busy_next = 1'b0;
            else
            begin
                cnt_next = cnt_reg - 6'd1;
                quo_next = {quo_reg[31:0], 1'b0};
                if (!trial[33])
                    rem_next = trial[32:0];
                else
                    rem_next = {rem_reg[31:0], quo_reg[32]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end
endmodule

FILE: hw/rtl/lrh_back.sv
module lrh_back #(
    parameter int ADDR_BITS   = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lrh_pkg::item_t         item,
    input  logic                   item_valid,
    output logic                   item_pop,
    input  logic [16:0]            loop_length,
    input  logic [19:0]            speed,
    input  logic [15:0]            level_gain,
    input  logic [15:0]            ramp_step,
    output logic                   res_valid,
    input  logic                   res_free,
    output logic [SAMPLE_BITS-1:0] res_sample,
    output logic                   res_wrapped,
    output logic [15:0]            res_meter
);
    import lrh_pkg::*;

    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int IB        = 32 - FRAC_BITS;
    localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

    logic signed [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    state_t state_reg, state_next;
    logic [31:0] pos_reg, pos_next;
    logic [16:0] mute_reg, mute_next;
    logic [15:0] peak_reg, peak_next;
    logic [ADDR_BITS:0] len_reg;
    logic [ADDR_BITS-1:0] i0_reg, i1_reg, rd_addr;
    logic signed [SAMPLE_BITS-1:0] s0_reg;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic wrapped_reg;
    logic [32:0] sum;
    logic div_start, div_done;
    logic [31:0] div_rem;
    logic [IB-1:0] ipart;
    logic [FRAC_BITS:0] frac, ifrac;
    logic [ADDR_BITS:0] i0_wide, i1_wide;
    logic [IB:0] ip_mod;
    logic signed [63:0] prod, rnd, yv;
    logic [16:0] tgt, up, dn;
    logic [SAMPLE_BITS-1:0] absy;
    logic [31:0] decay;

    assign ipart = pos_reg[31:FRAC_BITS];
    assign frac  = {1'b0, pos_reg[FRAC_BITS-1:0]};
    assign ifrac = (FRAC_BITS+1)'(1 << FRAC_BITS) - frac;
    assign sum   = {1'b0, pos_reg} + 33'(speed);

    // the index pass starts from idle, the advance pass from the meter step
    lrh_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (state_reg == ST_IDLE ? 33'(ipart) : sum),
        .divisor   (state_reg == ST_IDX ? 32'(len_reg) : item.wrap_pos),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign ip_mod  = div_rem[IB:0];
    assign i0_wide = (ADDR_BITS+1)'(ip_mod);
    assign i1_wide = (i0_wide + 1'b1 == len_reg) ? '0 : i0_wide + 1'b1;

    always_comb
    begin
        unique case (state_reg)
            ST_RD0:  rd_addr = i0_reg;
            default: rd_addr = i1_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && item_valid && item.cmd == CMD_WRITE)
            mem[item.write_address[ADDR_BITS-1:0]] <= item.write_sample[SAMPLE_BITS-1:0];
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        tgt  = item.muted ? 17'd0 : UNITY_MUTE;
        up   = mute_reg + 17'(ramp_step);
        dn   = (mute_reg > 17'(ramp_step)) ? mute_reg - 17'(ramp_step) : 17'd0;
        prod = '0;
        rnd  = '0;
        yv   = '0;
        state_next = state_reg;
        pos_next   = pos_reg;
        mute_next  = mute_reg;
        peak_next  = peak_reg;
        acc_next   = acc_reg;
        item_pop   = 1'b0;
        div_start  = 1'b0;
        absy  = y_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-y_reg) : y_reg;
        decay = 32'(peak_reg) * 32'(DECAY_Q16);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.cmd)
                        CMD_LOAD:
                        begin
                            pos_next = item.sync_position;
                            item_pop = 1'b1;
                        end
                        CMD_WRITE:
                            item_pop = 1'b1;
                        CMD_TICK:
                        begin
                            if (!res_valid || res_free)
                            begin
                                if (len_reg == '0)
                                begin
                                    acc_next   = '0;
                                    state_next = ST_GAIN;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = ST_IDX;
                                end
                            end
                        end
                        default:
                            item_pop = 1'b1;
                    endcase
                end
            end
            ST_IDX:
                if (div_done)
                    state_next = ST_RD0;
            ST_RD0:
                state_next = ST_RD1;
            ST_RD1:
                state_next = ST_MUL0;
            ST_MUL0:
            begin
                acc_next   = 64'(s0_reg) * 64'(signed'({1'b0, ifrac}));
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                prod = 64'(rd_data_reg) * 64'(signed'({1'b0, frac}));
                rnd  = acc_reg + prod + (64'sd1 <<< (FRAC_BITS - 1));
                acc_next   = rnd >>> FRAC_BITS;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                if (mute_reg < tgt)
                    mute_next = (up > tgt) ? tgt : up;
                else if (mute_reg > tgt)
                    mute_next = (dn < tgt) ? tgt : dn;
                state_next = ST_MUTE;
            end
            ST_MUTE:
                state_next = ST_METER;
            ST_METER:
            begin
                if (32'(absy) > 32'(peak_reg))
                    peak_next = 16'(absy);
                else
                    peak_next = decay[31:16];
                if (item.wrap_pos != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DIV:
                if (div_done)
                begin
                    pos_next   = div_rem;
                    state_next = ST_DONE;
                end
            ST_DONE:
            begin
                item_pop   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
        // gained sample fits SAMPLE_BITS+4 signed bits
        yv = 64'(signed'(x_reg[SAMPLE_BITS+4:0])) * 64'(signed'({1'b0, mute_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            mute_reg  <= UNITY_MUTE;
            peak_reg  <= '0;
            res_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            mute_reg  <= mute_next;
            peak_reg  <= peak_next;
            if (state_reg == ST_DONE)
                res_valid <= 1'b1;
            else if (res_free)
                res_valid <= 1'b0;
        end
    end

    logic signed [63:0] xr, yr;

    // the interpolated sample always fits SAMPLE_BITS
    always_comb
    begin
        xr = (64'(signed'(acc_reg[SAMPLE_BITS-1:0])) * 64'(signed'({1'b0, level_gain}))
              + (64'sd1 <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
        yr = (yv + (64'sd1 <<< (MUTE_SHIFT - 1))) >>> MUTE_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == ST_IDLE)
            len_reg <= (32'(loop_length) > 32'(MEM_DEPTH)) ? (ADDR_BITS+1)'(MEM_DEPTH)
                                                           : (ADDR_BITS+1)'(loop_length);
        if (state_reg == ST_IDX && div_done)
        begin
            i0_reg <= i0_wide[ADDR_BITS-1:0];
            i1_reg <= i1_wide[ADDR_BITS-1:0];
        end
        if (state_reg == ST_RD1)
            s0_reg <= rd_data_reg;
        if (state_reg == ST_GAIN)
            x_reg <= xr;
        if (state_reg == ST_MUTE)
            y_reg <= (yr > SMAX) ? SAMPLE_BITS'(SMAX)
                   : (yr < SMIN) ? SAMPLE_BITS'(SMIN) : yr[SAMPLE_BITS-1:0];
        if (state_reg == ST_METER)
            wrapped_reg <= (item.wrap_pos != '0) && (sum >= 33'(item.wrap_pos));
        if (state_reg == ST_DONE)
        begin
            res_sample  <= y_reg;
            res_wrapped <= wrapped_reg;
            res_meter   <= peak_next;
        end
    end
endmodule

FILE: hw/rtl/loop_read_head_interpolating_core.sv
// Loop playback head with linear interpolation.
// Input channel: push/full carry one item: a tick, a position load or a
// sample write into the loop memory. Result channel: empty/pop present one
// result per tick (sample, wrap flag, meter level); other commands give none.
// Configuration: cfg_we/cfg_index/cfg_data write loop_length, speed,
// level_gain and ramp_step; write them only while the block is idle.
// A two-entry queue sits between the input side and the execution unit.
// Loads and writes retire in the cycle in which they reach the head of the queue.
// A tick accepted into an idle block makes two passes through a one-bit-per-cycle
// divider (read index modulo loop length, then position modulo wrap point)
// and also goes through memory reads, multiply steps and handoff. A zero loop
// length skips the first pass, the reads and the multiply steps, a zero wrap
// point the second pass.
// One result register holds the finished result; while it is not popped the
// next tick waits at the head of the queue, the items behind it wait too and
// full rises once the queue is full.
// Reset clears position, meter and queue and sets the mute level to unity;
// loop memory contents are undefined until written.
module loop_read_head_interpolating_core #(
    parameter int ADDR_BITS   = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             cmd,
    input  logic                   muted,
    input  logic [31:0]            wrap_pos,
    input  logic [31:0]            sync_position,
    input  logic [ADDR_BITS-1:0]   write_address,
    input  logic signed [SAMPLE_BITS-1:0] write_sample,
    output logic                   empty,
    input  logic                   pop,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic                   wrapped,
    output logic [15:0]            meter_level,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [19:0]            cfg_data
);
    import lrh_pkg::*;

    logic [16:0] loop_length_reg;
    logic [19:0] speed_reg;
    logic [15:0] level_gain_reg;
    logic [15:0] ramp_step_reg;
    logic q_push, q_full, q_empty, q_pop, res_valid;
    item_t q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_length_reg <= '0;
            speed_reg       <= 20'd65536;
            level_gain_reg  <= 16'd4096;
            ramp_step_reg   <= 16'd68;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                2'(REG_LOOP_LENGTH): loop_length_reg <= cfg_data[16:0];
                2'(REG_SPEED):       speed_reg       <= cfg_data;
                2'(REG_LEVEL_GAIN):  level_gain_reg  <= cfg_data[15:0];
                default:             ramp_step_reg   <= cfg_data[15:0];
            endcase
        end
    end

    lrh_front #(.ADDR_BITS(ADDR_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .push(push), .full(full), .cmd(cmd),
        .muted(muted), .wrap_pos(wrap_pos), .sync_position(sync_position),
        .write_address(write_address), .write_sample(write_sample),
        .q_push(q_push), .q_item(q_in), .q_full(q_full)
    );

    lrh_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(q_in),
        .full(q_full), .pop(q_pop), .pop_item(q_out), .empty(q_empty)
    );

    lrh_back #(.ADDR_BITS(ADDR_BITS), .SAMPLE_BITS(SAMPLE_BITS),
               .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .item(q_out), .item_valid(!q_empty),
        .item_pop(q_pop), .loop_length(loop_length_reg), .speed(speed_reg),
        .level_gain(level_gain_reg), .ramp_step(ramp_step_reg),
        .res_valid(res_valid), .res_free(pop), .res_sample(out_sample),
        .res_wrapped(wrapped), .res_meter(meter_level)
    );

    assign empty = !res_valid;
endmodule
